// ===== sv/integer_to_ascii_formatter_defines.svh =====
// Assertion macros shared by the checker of the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, ignored while reset is active.
`define ITA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is active.
`define ITA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define ITA_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ita_pkg.sv =====
package ita_pkg;

    // Default sizes of the formatter.
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Character codes.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    // Radix selection codes.
    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } ita_radix_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_LEAD,
        ST_SIGN,
        ST_MID,
        ST_DIGIT,
        ST_TAIL
    } ita_state_t;

    // Input word.
    typedef struct packed {
        logic [31:0] magnitude;
        logic [1:0]  radix_code;
        logic        negative;
        logic [6:0]  field_width;
        logic        left_adjust;
        logic        zero_pad;
        logic        upper_case;
    } ita_in_t;

    // Output word.
    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } ita_out_t;

    // Commands from the sequencer to the digit register.
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } ita_dig_ctl_t;

    // Number of decimal digits of the largest value of vb bits
    // (1233 / 4096 approximates log10 of two).
    function automatic int bcd_digits(input int vb);
        return (vb * 1233) / 4096 + 1;
    endfunction

    // Width of the digit register: holds the BCD form and the binary form, and is a
    // multiple of 12 so that 1, 3 and 4 bit digit groups all align to its top.
    function automatic int reg_bits(input int vb);
        return 12 * ((4 * bcd_digits(vb) + 11) / 12);
    endfunction

    // ASCII character for one digit value.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d <= DIGIT_MAX) begin
            return CH_ZERO + {4'b0, d};
        end
        return base + {4'b0, d} - LETTER_OFS;
    endfunction

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter.
// The s_ channel takes one word per number: magnitude, radix code, sign, field width
// and the left adjust, zero pad and upper case flags. The m_ channel returns the padded
// text one character per word, most significant first, with last_char set on the
// final character of each number.
// An input word is taken only while the formatter is idle. A decimal number first
// runs shift-and-add-3 conversion; every radix then shifts the leading zero digit
// slots out of the digit register until the leading digit is at its top. After that
// the characters leave at one per cycle while the receiver takes them.
// The next input word is accepted in the cycle after the last character has been
// registered, even while that character still waits for the receiver.
// When m_ready is low a valid character holds and the formatter waits before emitting the next one.
// Reset (aresetn low at a clock edge) empties the output register and returns the
// formatter to idle, ready for a new word.
module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH  = ita_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ita_pkg::ita_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ita_pkg::ita_out_t m_data
);
    import ita_pkg::*;

    localparam int R      = reg_bits(VALUE_BITS);
    localparam int ND_W   = $clog2(R + 1);
    localparam int PAD_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = ((ND_W > PAD_W) ? ND_W : PAD_W) + 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int NS_BIN = R;
    localparam int NS_OCT = R / 3;
    localparam int NS_HEX = R / 4;

    ita_state_t       state_reg, state_next;
    logic [ND_W-1:0]  nd_reg, nd_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic [PAD_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             left_reg, left_next;
    logic             zero_reg, zero_next;
    logic             upper_reg, upper_next;
    logic             m_valid_reg, m_valid_next;
    ita_out_t         m_data_reg, m_data_next;

    ita_dig_ctl_t     dig_ctl;
    ita_radix_t       in_radix;
    logic [63:0]      mag_ext;
    logic [3:0]       top_digit;
    logic             top_zero;
    logic             emit_ok;
    logic             norm_step;
    logic             pad_left;
    logic [CW-1:0]    actual;
    logic [CW-1:0]    width_c;
    logic [PAD_W-1:0] pad_calc;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;

    assign in_radix = ita_radix_t'(s_data.radix_code);
    assign mag_ext  = 64'(s_data.magnitude);

    // Digit register: BCD conversion, leading zero scan and digit shift-out.
    ita_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digits (
        .aclk      (aclk),
        .ctl       (dig_ctl),
        .load_value(mag_ext[VALUE_BITS-1:0]),
        .load_radix(in_radix),
        .top_digit (top_digit),
        .top_zero  (top_zero)
    );

    // Shared conditions of the sequencer.
    assign emit_ok   = !m_valid_reg || m_ready;
    assign norm_step = top_zero && (nd_reg > ND_W'(1));
    assign pad_left  = (pad_reg != '0);
    assign actual    = CW'(nd_reg) + CW'(neg_reg);
    assign width_c   = CW'(width_reg);
    assign pad_calc  = (width_c > actual) ? PAD_W'(width_c - actual) : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (in_radix == RADIX_DEC) ? ST_CONV : ST_NORM;
                end
            end
            ST_CONV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (!norm_step) begin
                    if (left_reg) begin
                        state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                    end else if (zero_reg && neg_reg) begin
                        state_next = ST_SIGN;
                    end else if (pad_calc != '0) begin
                        state_next = ST_LEAD;
                    end else begin
                        state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                end
            end
            ST_LEAD: begin
                if (emit_ok && pad_reg == PAD_W'(1)) begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (emit_ok) begin
                    state_next = (!left_reg && pad_left) ? ST_MID : ST_DIGIT;
                end
            end
            ST_MID: begin
                if (emit_ok && pad_reg == PAD_W'(1)) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (emit_ok && nd_reg == ND_W'(1)) begin
                    state_next = (left_reg && pad_left) ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (emit_ok && pad_reg == PAD_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and the character produced in each state.
    always_comb begin
        nd_next    = nd_reg;
        pad_next   = pad_reg;
        width_next = width_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        left_next  = left_reg;
        zero_next  = zero_reg;
        upper_next = upper_reg;
        dig_ctl    = '0;
        emit       = 1'b0;
        emit_char  = CH_SPACE;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dig_ctl.load = 1'b1;
                    neg_next     = s_data.negative;
                    left_next    = s_data.left_adjust;
                    zero_next    = s_data.zero_pad;
                    upper_next   = s_data.upper_case;
                    width_next   = (s_data.field_width > 7'(MAX_WIDTH)) ?
                                   PAD_W'(MAX_WIDTH) : PAD_W'(s_data.field_width);
                    cnt_next     = CNT_W'(VALUE_BITS);
                    case (in_radix)
                        RADIX_BIN: nd_next = ND_W'(NS_BIN);
                        RADIX_OCT: nd_next = ND_W'(NS_OCT);
                        default:   nd_next = ND_W'(NS_HEX);
                    endcase
                end
            end
            ST_CONV: begin
                dig_ctl.dabble = 1'b1;
                cnt_next       = cnt_reg - CNT_W'(1);
            end
            ST_NORM: begin
                if (norm_step) begin
                    dig_ctl.shift = 1'b1;
                    nd_next       = nd_reg - ND_W'(1);
                end else begin
                    pad_next = pad_calc;
                end
            end
            ST_LEAD: begin
                if (emit_ok) begin
                    emit      = 1'b1;
                    emit_char = zero_reg ? CH_ZERO : CH_SPACE;
                    pad_next  = pad_reg - PAD_W'(1);
                end
            end
            ST_SIGN: begin
                if (emit_ok) begin
                    emit      = 1'b1;
                    emit_char = CH_MINUS;
                end
            end
            ST_MID: begin
                if (emit_ok) begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO;
                    pad_next  = pad_reg - PAD_W'(1);
                end
            end
            ST_DIGIT: begin
                if (emit_ok) begin
                    emit          = 1'b1;
                    emit_char     = digit_char(top_digit, upper_reg);
                    emit_last     = (nd_reg == ND_W'(1)) && !(left_reg && pad_left);
                    dig_ctl.shift = 1'b1;
                    nd_next       = nd_reg - ND_W'(1);
                end
            end
            ST_TAIL: begin
                if (emit_ok) begin
                    emit      = 1'b1;
                    emit_char = CH_SPACE;
                    emit_last = (pad_reg == PAD_W'(1));
                    pad_next  = pad_reg - PAD_W'(1);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Output register: loads a new word or empties once the current one is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next           = 1'b1;
            m_data_next.ascii_char = emit_char;
            m_data_next.last_char  = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and counters, meaningful only inside an item.
    always_ff @(posedge aclk) begin
        nd_reg     <= nd_next;
        pad_reg    <= pad_next;
        width_reg  <= width_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        left_reg   <= left_next;
        zero_reg   <= zero_next;
        upper_reg  <= upper_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/ita_digits.sv =====
module ita_digits #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  ita_pkg::ita_dig_ctl_t ctl,
    input  logic [VALUE_BITS-1:0] load_value,
    input  ita_pkg::ita_radix_t   load_radix,
    output logic [3:0]            top_digit,
    output logic                  top_zero
);
    import ita_pkg::*;

    localparam int R     = reg_bits(VALUE_BITS);
    localparam int LANES = R / 4;

    logic [R-1:0]          num_reg;
    logic [R-1:0]          num_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    ita_radix_t            radix_reg;
    ita_radix_t            radix_next;
    logic [R-1:0]          adj;

    // Add three to every BCD digit of five or more before the next shift.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        assign adj[4*i +: 4] = (num_reg[4*i +: 4] >= 4'd5) ?
                               num_reg[4*i +: 4] + 4'd3 : num_reg[4*i +: 4];
    end

    // Leading digit at the top of the register, sized by the radix.
    always_comb begin
        case (radix_reg)
            RADIX_BIN: top_digit = {3'b0, num_reg[R-1]};
            RADIX_OCT: top_digit = {1'b0, num_reg[R-1 -: 3]};
            default:   top_digit = num_reg[R-1 -: 4];
        endcase
    end

    assign top_zero = (top_digit == 4'd0);

    // Load, one double-dabble step, or one digit shift toward the top.
    always_comb begin
        num_next   = num_reg;
        bin_next   = bin_reg;
        radix_next = radix_reg;
        if (ctl.load) begin
            radix_next = load_radix;
            bin_next   = load_value;
            num_next   = (load_radix == RADIX_DEC) ? '0 : R'(load_value);
        end else if (ctl.dabble) begin
            num_next = {adj[R-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
        end else if (ctl.shift) begin
            case (radix_reg)
                RADIX_BIN: num_next = {num_reg[R-2:0], 1'b0};
                RADIX_OCT: num_next = {num_reg[R-4:0], 3'b0};
                default:   num_next = {num_reg[R-5:0], 4'b0};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        num_reg   <= num_next;
        bin_reg   <= bin_next;
        radix_reg <= radix_next;
    end

endmodule

// ===== sv/ita_checker.sv =====
`include "integer_to_ascii_formatter_defines.svh"

module ita_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ita_pkg::ita_out_t m_data
);
    import ita_pkg::*;

    // A stalled output word holds its value.
    `ITA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "output word changed while stalled")

    // Once a word is taken the formatter is busy in the next cycle.
    `ITA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted twice in a row")

    // While idle, the only word still waiting is the final character of a number.
    `ITA_ASSERT_IMP(a_idle_last_only, aclk, aresetn, s_ready && m_valid, m_data.last_char, "idle with an unfinished number")

    // A character that is not the last one is followed at once by the next character.
    `ITA_ASSERT_NXT(a_mid_number_next, aclk, aresetn, m_valid && m_ready && !m_data.last_char, m_valid, "gap in the middle of a number")

    // Reset empties the output and makes the formatter ready.
    `ITA_ASSERT_RST(a_reset_state, aclk, !aresetn, s_ready && !m_valid, "wrong state after reset")

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);
